// ===== design/amd_pkg.sv =====
// Package with the register map, reset values and defaults of the amplitude Manchester demodulator.
`default_nettype none

package amd_pkg;

	localparam int unsigned ErrorLimitDefault = 64;
	localparam int unsigned SumWidthDefault   = 20;

	localparam int unsigned ClockWidth  = 13;
	localparam int unsigned OffsetWidth = 20;
	localparam int unsigned ThrWidth    = 8;
	localparam int unsigned DcWidth     = 8;
	localparam int unsigned SampleWidth = 8;
	localparam int unsigned PhaseWidth  = 12;
	localparam int unsigned HalfWidth   = 12;
	localparam int unsigned ErrWidth    = 7;
	localparam int unsigned CfgWidth    = 20;
	localparam int unsigned IndexWidth  = 2;

	localparam logic [ClockWidth-1:0] ClockMin   = 13'd2;
	localparam logic [ClockWidth-1:0] ClockMax   = 13'd4096;
	localparam logic [ClockWidth-1:0] ClockReset = 13'd768;
	localparam logic [ThrWidth-1:0]   ThrReset   = 8'd16;

	typedef enum logic [IndexWidth-1:0] {
		REG_BIT_CLOCK       = 2'd0,
		REG_START_OFFSET    = 2'd1,
		REG_LEVEL_THRESHOLD = 2'd2,
		REG_DC_OFFSET       = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		FEED_NONE = 2'd0,
		FEED_BIT  = 2'd1,
		FEED_STOP = 2'd2
	} feed_code_t;

	typedef struct packed {
		logic                pend_valid;
		logic                pend_level;
		logic [ErrWidth-1:0] err_count;
		logic                stopped;
	} dec_state_t;

	typedef struct packed {
		dec_state_t st;
		feed_code_t code;
		logic       bit_val;
	} feed_res_t;

endpackage

`default_nettype wire

// ===== design/amplitude_manchester_demodulator_top.sv =====
// Top level of the amplitude Manchester demodulator with its stream ports and register port.
`default_nettype none

// Amplitude samples enter on the slave stream, one transfer per cycle at full rate unless the
// result register stalls. Each is held in the input register, then passes through the accumulate,
// half-judge and pair-decode logic into the result register. At most one result leaves on the
// master stream per sample; a stalled result register holds the input register and slave side.
// The half decision compares 2*sum+half against 2*threshold*half, so no divider is needed.
// When the error limit is reached a single result with the give-up flag is sent and further
// samples are dropped until the sample marked last, after which all decoder state clears.
module amplitude_manchester_demodulator_top
	import amd_pkg::*;
#(
	parameter int unsigned ERROR_LIMIT = ErrorLimitDefault,
	parameter int unsigned SUM_WIDTH   = SumWidthDefault
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [SampleWidth-1:0] s_tdata,  // [7:0] sample (signed)
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [7:0]                  m_tdata,  // [0] bit_res, [7:1] zero
	output logic                        m_tuser,  // [0] gave_up
	input  wire logic                   cfg_we,
	input  wire logic [IndexWidth-1:0]  cfg_index,
	input  wire logic [CfgWidth-1:0]    cfg_data
);

	localparam int unsigned JW = (SUM_WIDTH + 2 > 22) ? SUM_WIDTH + 2 : 22;
	localparam logic [ErrWidth-1:0] ErrLimit = ErrWidth'(ERROR_LIMIT);
	localparam logic [SUM_WIDTH:0] SumMax = {1'b0, {SUM_WIDTH{1'b1}}};

	function automatic feed_res_t feed_half(input dec_state_t d, input logic lvl);
		feed_res_t r;
		r.st      = d;
		r.code    = FEED_NONE;
		r.bit_val = 1'b0;
		if (!d.pend_valid) begin
			r.st.pend_valid = 1'b1;
			r.st.pend_level = lvl;
		end else if (d.pend_level != lvl) begin
			r.bit_val       = d.pend_level;
			r.st.pend_valid = 1'b0;
			r.code          = FEED_BIT;
		end else begin
			r.st.err_count = d.err_count + 1'b1;
			if (r.st.err_count >= ErrLimit) begin
				r.st.stopped = 1'b1;
				r.code       = FEED_STOP;
			end
		end
		return r;
	endfunction

	logic [ClockWidth-1:0]  bit_clock_q;
	logic [OffsetWidth-1:0] start_offset_q;
	logic [ThrWidth-1:0]    threshold_q;
	logic [DcWidth-1:0]     dc_offset_q;

	logic [OffsetWidth-1:0] skip_q;
	logic [PhaseWidth-1:0]  phase_q;
	logic [SUM_WIDTH-1:0]   sum_q;
	logic                   first_level_q;
	dec_state_t             dec_q;

	logic                   valid_s1;
	logic [SampleWidth-1:0] sample_s1;
	logic                   last_s1;

	logic out_valid_q;
	logic out_bit_q;
	logic out_gave_q;

	logic proceed;

	logic [ClockWidth-1:0]  clk_eff;
	logic [HalfWidth-1:0]   half;
	logic [ClockWidth-1:0]  two_half;
	logic [ClockWidth-1:0]  phase_ext;
	logic [ClockWidth-1:0]  phase_inc;
	logic signed [8:0]      diff;
	logic [8:0]             diff_abs;
	logic [7:0]             mag;
	logic [SUM_WIDTH:0]     sum_wide;
	logic [SUM_WIDTH-1:0]   sum_sat;
	logic [JW-1:0]          judge_lhs;
	logic [JW-1:0]          judge_rhs;
	logic                   level_now;

	logic [OffsetWidth-1:0] skip_d;
	logic [PhaseWidth-1:0]  phase_d;
	logic [SUM_WIDTH-1:0]   sum_d;
	logic                   first_level_d;
	dec_state_t             dec_d;
	logic                   emit;
	logic                   emit_bit;
	logic                   emit_gave;
	feed_res_t              f1;
	feed_res_t              f2;

	assign proceed  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || proceed;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_bit_q};
	assign m_tuser  = out_gave_q;

	always_comb begin
		if (bit_clock_q < ClockMin) begin
			clk_eff = ClockMin;
		end else if (bit_clock_q > ClockMax) begin
			clk_eff = ClockMax;
		end else begin
			clk_eff = bit_clock_q;
		end
		half      = clk_eff[ClockWidth-1:1];
		two_half  = {half, 1'b0};
		phase_ext = {1'b0, phase_q};
		phase_inc = phase_ext + 1'b1;

		diff     = $signed({sample_s1[7], sample_s1}) - $signed({dc_offset_q[7], dc_offset_q});
		diff_abs = diff[8] ? 9'(-diff) : 9'(diff);
		mag      = diff_abs[7:0];

		sum_wide = {1'b0, sum_q} + {{(SUM_WIDTH - 7){1'b0}}, mag};
		sum_sat  = (sum_wide > SumMax) ? SumMax[SUM_WIDTH-1:0] : sum_wide[SUM_WIDTH-1:0];

		judge_lhs = JW'({sum_sat, 1'b0}) + JW'(half);
		judge_rhs = (JW'(threshold_q) * JW'(half)) << 1;
		level_now = judge_lhs >= judge_rhs;

		skip_d        = skip_q;
		phase_d       = phase_q;
		sum_d         = sum_q;
		first_level_d = first_level_q;
		dec_d         = dec_q;
		emit          = 1'b0;
		emit_bit      = 1'b0;
		emit_gave     = 1'b0;
		f1            = feed_half(dec_q, first_level_q);
		f2            = feed_half(f1.st, level_now);

		if (!dec_q.stopped) begin
			if (skip_q < start_offset_q) begin
				skip_d = skip_q + 1'b1;
			end else begin
				if (phase_ext < two_half) begin
					sum_d = sum_sat;
					if (phase_ext == ClockWidth'(half - 1'b1)) begin
						first_level_d = level_now;
						sum_d         = '0;
					end else if (phase_ext == two_half - 1'b1) begin
						sum_d = '0;
						if (f1.code == FEED_STOP) begin
							dec_d     = f1.st;
							emit      = 1'b1;
							emit_gave = 1'b1;
						end else begin
							dec_d = f2.st;
							if (f1.code == FEED_BIT) begin
								emit     = 1'b1;
								emit_bit = f1.bit_val;
							end
							if (f2.code == FEED_BIT) begin
								emit     = 1'b1;
								emit_bit = f2.bit_val;
							end else if (f2.code == FEED_STOP) begin
								emit      = 1'b1;
								emit_bit  = 1'b0;
								emit_gave = 1'b1;
							end
						end
					end
				end
				phase_d = (phase_inc >= clk_eff) ? '0 : phase_inc[PhaseWidth-1:0];
			end
		end

		if (last_s1) begin
			skip_d        = '0;
			phase_d       = '0;
			sum_d         = '0;
			first_level_d = 1'b0;
			dec_d         = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_clock_q    <= ClockReset;
			start_offset_q <= '0;
			threshold_q    <= ThrReset;
			dc_offset_q    <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_BIT_CLOCK:       bit_clock_q    <= cfg_data[ClockWidth-1:0];
				REG_START_OFFSET:    start_offset_q <= cfg_data[OffsetWidth-1:0];
				REG_LEVEL_THRESHOLD: threshold_q    <= cfg_data[ThrWidth-1:0];
				REG_DC_OFFSET:       dc_offset_q    <= cfg_data[DcWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			skip_q        <= '0;
			phase_q       <= '0;
			sum_q         <= '0;
			first_level_q <= 1'b0;
			dec_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (valid_s1 && proceed) begin
				skip_q        <= skip_d;
				phase_q       <= phase_d;
				sum_q         <= sum_d;
				first_level_q <= first_level_d;
				dec_q         <= dec_d;
			end
			if (proceed) begin
				out_valid_q <= valid_s1 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			sample_s1 <= s_tdata;
			last_s1   <= s_tlast;
		end
		if (proceed) begin
			out_bit_q  <= emit_bit;
			out_gave_q <= emit_gave;
		end
	end

endmodule

`default_nettype wire
